/* sv/pixel_window_gamma_stretch_macros.svh */
// assertion macros for the window/level gamma stretch block
// used by pixel_window_gamma_stretch.sv, no other dependencies
`ifndef PIXEL_WINDOW_GAMMA_STRETCH_MACROS_SVH
`define PIXEL_WINDOW_GAMMA_STRETCH_MACROS_SVH

// implication check, disabled while reset is held
`define PWGS_ASSERT_IMPL(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never hold outside reset
`define PWGS_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

/* sv/pwgs_pkg.sv */
// shared types and constants of the window/level gamma stretch block
// no dependencies
`default_nettype none

package pwgs_pkg;

    localparam int SAMPLE_W        = 16;
    localparam int BYTE_W          = 8;
    localparam int BPP_W           = 2;
    localparam int GAIN_W          = 24;
    localparam int CODE_W          = 8;
    localparam int TIDX_W          = 10;
    localparam int LVL_W           = 10;
    localparam int LEVEL_FRAC_BITS = 2;
    localparam int LEVEL_MID_Q     = 512;
    localparam int LEVEL_MAX_Q     = 1020;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 24;
    localparam int DIFF_W          = SAMPLE_W + 1;
    localparam int PROD_W          = GAIN_W + 1 + DIFF_W;

    localparam logic [CODE_W-1:0] OVERLOAD_CODE = 8'd255;

    localparam logic CMD_CONVERT     = 1'b0;
    localparam logic CMD_TABLE_WRITE = 1'b1;

    localparam logic [BPP_W-1:0]    RST_BYTES_PER_PIXEL  = 2'd1;
    localparam logic [SAMPLE_W-1:0] RST_SATURATION_LIMIT = 16'hFFFF;
    localparam logic [SAMPLE_W-1:0] RST_BLACK_OFFSET     = 16'h0000;
    localparam logic [GAIN_W-1:0]   RST_LEVEL_GAIN       = 24'h010000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BYTES_PER_PIXEL  = 2'd0,
        CFG_SATURATION_LIMIT = 2'd1,
        CFG_BLACK_OFFSET     = 2'd2,
        CFG_LEVEL_GAIN       = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [BPP_W-1:0]    bytes_per_pixel;
        logic [SAMPLE_W-1:0] saturation_limit;
        logic [SAMPLE_W-1:0] black_offset;
        logic [GAIN_W-1:0]   level_gain;
    } t_cfg;

    // table access issued by the level pipe
    typedef struct packed {
        logic conv;   // convert beat, produces one result
        logic wr;     // table write
        logic sat;    // sample above saturation limit
    } t_mem_ctl;

endpackage

`default_nettype wire

/* sv/pixel_window_gamma_stretch.sv */
// top level of the window/level gamma display stretch
// depends on pwgs_pkg, pwgs_level, pwgs_gamma_mem and the assertion macro header
`default_nettype none
`include "pixel_window_gamma_stretch_macros.svh"

// usage
//   command channel: a beat is taken at each rising edge with i_start high and
//   o_busy low; o_busy stays low, so one beat can enter every clock cycle
//   command convert: the pixel bytes become one display code, command table
//   write: i_table_value is stored at i_table_index and no result comes back
//   result channel: o_done is high for exactly one cycle with o_display_code,
//   the receiver has no way to hold it off and needs none
//   pipeline: three register stages (sample/difference, gain product, table
//   read) lie between a taken convert beat and its result; throughput is one
//   beat per clock
//   the table sits in one single-port memory; writes and reads use it at the
//   same pipe stage, so they keep beat order with no forwarding
//   config writes (i_cfg_we) are registered; the user makes them while the pipe
//   is empty, not enforced; the gamma table must be loaded before pixels are sent
//   reset: synchronous on i_rst_n, clears the pipe valids and restores the
//   config registers; table contents are kept and are undefined at power up
module pixel_window_gamma_stretch #(
    parameter int TABLE_DEPTH         = 1024,
    parameter int MAX_BYTES_PER_PIXEL = 2,
    parameter int GAIN_FRAC_BITS      = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    output logic                                     o_busy,
    input  wire logic                                i_command,
    input  wire logic [pwgs_pkg::BYTE_W-1:0]         i_pixel_low_byte,
    input  wire logic [pwgs_pkg::BYTE_W-1:0]         i_pixel_high_byte,
    input  wire logic [pwgs_pkg::TIDX_W-1:0]         i_table_index,
    input  wire logic [pwgs_pkg::CODE_W-1:0]         i_table_value,
    input  wire logic                                i_cfg_we,
    input  wire logic [pwgs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [pwgs_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic                                     o_done,
    output logic [pwgs_pkg::CODE_W-1:0]              o_display_code
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);

    pwgs_pkg::t_cfg      r_cfg;
    pwgs_pkg::t_cfg      n_cfg;
    pwgs_pkg::t_mem_ctl  mem_ctl;
    logic [ADDR_W-1:0]   mem_addr;
    logic [pwgs_pkg::CODE_W-1:0] mem_wdata;
    logic                beat;

    // the pipe never stalls
    assign o_busy = 1'b0;
    assign beat   = i_start && !o_busy;

    // config register decode
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (pwgs_pkg::t_cfg_reg'(i_cfg_index))
                pwgs_pkg::CFG_BYTES_PER_PIXEL: begin
                    n_cfg.bytes_per_pixel = i_cfg_data[pwgs_pkg::BPP_W-1:0];
                end
                pwgs_pkg::CFG_SATURATION_LIMIT: begin
                    n_cfg.saturation_limit = i_cfg_data[pwgs_pkg::SAMPLE_W-1:0];
                end
                pwgs_pkg::CFG_BLACK_OFFSET: begin
                    n_cfg.black_offset = i_cfg_data[pwgs_pkg::SAMPLE_W-1:0];
                end
                pwgs_pkg::CFG_LEVEL_GAIN: begin
                    n_cfg.level_gain = i_cfg_data[pwgs_pkg::GAIN_W-1:0];
                end
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bytes_per_pixel  <= pwgs_pkg::RST_BYTES_PER_PIXEL;
            r_cfg.saturation_limit <= pwgs_pkg::RST_SATURATION_LIMIT;
            r_cfg.black_offset     <= pwgs_pkg::RST_BLACK_OFFSET;
            r_cfg.level_gain       <= pwgs_pkg::RST_LEVEL_GAIN;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // sample -> level pipe, ends in a table address
    pwgs_level #(
        .TABLE_DEPTH         (TABLE_DEPTH),
        .MAX_BYTES_PER_PIXEL (MAX_BYTES_PER_PIXEL),
        .GAIN_FRAC_BITS      (GAIN_FRAC_BITS),
        .ADDR_W              (ADDR_W)
    ) u_level (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_beat            (beat),
        .i_command         (i_command),
        .i_pixel_low_byte  (i_pixel_low_byte),
        .i_pixel_high_byte (i_pixel_high_byte),
        .i_table_index     (i_table_index),
        .i_table_value     (i_table_value),
        .i_cfg             (r_cfg),
        .o_ctl             (mem_ctl),
        .o_addr            (mem_addr),
        .o_wdata           (mem_wdata)
    );

    // gamma table read/write and result register
    pwgs_gamma_mem #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_gamma_mem (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (mem_ctl),
        .i_addr         (mem_addr),
        .i_wdata        (mem_wdata),
        .o_done         (o_done),
        .o_display_code (o_display_code)
    );

    // every result traces back to a convert beat through stage 1, stage 2 and the result register
    `PWGS_ASSERT_IMPL(a_done_from_convert, i_clk, i_rst_n, o_done |-> $past(beat && (i_command == pwgs_pkg::CMD_CONVERT), 3), "result without convert beat")
    // every convert beat yields its result through stage 1, stage 2 and the result register
    `PWGS_ASSERT_IMPL(a_convert_gives_done, i_clk, i_rst_n, (beat && (i_command == pwgs_pkg::CMD_CONVERT)) |-> ##3 o_done, "convert beat lost")
    // a table write never produces a result
    `PWGS_ASSERT_NEVER(a_write_silent, i_clk, i_rst_n, $past(beat && (i_command == pwgs_pkg::CMD_TABLE_WRITE), 3) && o_done, "table write produced a result")

endmodule

`default_nettype wire

/* sv/pwgs_level.sv */
// level pipe: sample assembly, saturation test, gain multiply, q8.2 clamp
// depends on pwgs_pkg
`default_nettype none

module pwgs_level #(
    parameter int TABLE_DEPTH         = 1024,
    parameter int MAX_BYTES_PER_PIXEL = 2,
    parameter int GAIN_FRAC_BITS      = 16,
    parameter int ADDR_W              = 10
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_beat,
    input  wire logic                           i_command,
    input  wire logic [pwgs_pkg::BYTE_W-1:0]    i_pixel_low_byte,
    input  wire logic [pwgs_pkg::BYTE_W-1:0]    i_pixel_high_byte,
    input  wire logic [pwgs_pkg::TIDX_W-1:0]    i_table_index,
    input  wire logic [pwgs_pkg::CODE_W-1:0]    i_table_value,
    input  wire pwgs_pkg::t_cfg                 i_cfg,
    output pwgs_pkg::t_mem_ctl                  o_ctl,
    output logic [ADDR_W-1:0]                   o_addr,
    output logic [pwgs_pkg::CODE_W-1:0]         o_wdata
);

    localparam int SHIFT  = GAIN_FRAC_BITS - pwgs_pkg::LEVEL_FRAC_BITS;
    localparam int WIDE_W = ((ADDR_W > pwgs_pkg::TIDX_W) ? ADDR_W : pwgs_pkg::TIDX_W) + 1;
    localparam logic [WIDE_W-1:0] DEPTH_W = WIDE_W'(TABLE_DEPTH);
    localparam logic [WIDE_W-1:0] LAST_W  = WIDE_W'(TABLE_DEPTH - 1);

    // stage 1: sample, saturation, difference
    logic                                r_s1_vld;
    logic                                r_s1_cmd;
    logic                                r_s1_sat;
    logic                                r_s1_wr_ok;
    logic signed [pwgs_pkg::DIFF_W-1:0]  r_s1_diff;
    logic [ADDR_W-1:0]                   r_s1_tidx;
    logic [pwgs_pkg::CODE_W-1:0]         r_s1_tval;

    // stage 2: product
    logic                                r_s2_vld;
    logic                                r_s2_cmd;
    logic                                r_s2_sat;
    logic                                r_s2_wr_ok;
    logic signed [pwgs_pkg::PROD_W-1:0]  r_s2_prod;
    logic [ADDR_W-1:0]                   r_s2_tidx;
    logic [pwgs_pkg::CODE_W-1:0]         r_s2_tval;

    logic                                two_bytes;
    logic [pwgs_pkg::SAMPLE_W-1:0]       sample;
    logic [WIDE_W-1:0]                   tidx_wide;
    logic signed [pwgs_pkg::DIFF_W-1:0]  n_diff;
    logic signed [pwgs_pkg::PROD_W-1:0]  n_prod;
    logic signed [pwgs_pkg::PROD_W-1:0]  scaled;
    logic signed [pwgs_pkg::PROD_W-1:0]  lvl_sum;
    logic [pwgs_pkg::LVL_W-1:0]          lvl_q;
    logic [WIDE_W-1:0]                   lvl_wide;
    logic [ADDR_W-1:0]                   rd_addr;

    always_comb begin
        two_bytes = (MAX_BYTES_PER_PIXEL >= 2) && (i_cfg.bytes_per_pixel >= 2'd2);
        sample    = {(two_bytes ? i_pixel_high_byte : {pwgs_pkg::BYTE_W{1'b0}}),
                     i_pixel_low_byte};
        n_diff    = $signed({1'b0, sample}) - $signed({1'b0, i_cfg.black_offset});
        tidx_wide = WIDE_W'(i_table_index);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_beat;
            r_s2_vld <= r_s1_vld;
        end
    end

    assign n_prod = pwgs_pkg::PROD_W'($signed({1'b0, i_cfg.level_gain}) * r_s1_diff);

    always_ff @(posedge i_clk) begin
        r_s1_cmd   <= i_command;
        r_s1_sat   <= sample > i_cfg.saturation_limit;
        r_s1_wr_ok <= tidx_wide < DEPTH_W;
        r_s1_diff  <= n_diff;
        r_s1_tidx  <= tidx_wide[ADDR_W-1:0];
        r_s1_tval  <= i_table_value;

        r_s2_cmd   <= r_s1_cmd;
        r_s2_sat   <= r_s1_sat;
        r_s2_wr_ok <= r_s1_wr_ok;
        r_s2_prod  <= n_prod;
        r_s2_tidx  <= r_s1_tidx;
        r_s2_tval  <= r_s1_tval;
    end

    // floor to q8.2, center on mid level, clamp to 0..255.0
    always_comb begin
        scaled  = r_s2_prod >>> SHIFT;
        lvl_sum = scaled + pwgs_pkg::PROD_W'(pwgs_pkg::LEVEL_MID_Q);
        if (lvl_sum[pwgs_pkg::PROD_W-1]) begin
            lvl_q = '0;
        end else if (lvl_sum > $signed(pwgs_pkg::PROD_W'(pwgs_pkg::LEVEL_MAX_Q))) begin
            lvl_q = pwgs_pkg::LVL_W'(pwgs_pkg::LEVEL_MAX_Q);
        end else begin
            lvl_q = lvl_sum[pwgs_pkg::LVL_W-1:0];
        end
        lvl_wide = WIDE_W'(lvl_q);
        // small table: levels past the end use the last entry
        rd_addr  = (lvl_wide >= DEPTH_W) ? LAST_W[ADDR_W-1:0] : lvl_wide[ADDR_W-1:0];
    end

    always_comb begin
        o_ctl.conv = r_s2_vld && (r_s2_cmd == pwgs_pkg::CMD_CONVERT);
        o_ctl.wr   = r_s2_vld && (r_s2_cmd == pwgs_pkg::CMD_TABLE_WRITE) && r_s2_wr_ok;
        o_ctl.sat  = r_s2_sat;
        o_addr     = o_ctl.wr ? r_s2_tidx : rd_addr;
        o_wdata    = r_s2_tval;
    end

endmodule

`default_nettype wire

/* sv/pwgs_gamma_mem.sv */
// gamma table memory with registered read and result register
// depends on pwgs_pkg
`default_nettype none

module pwgs_gamma_mem #(
    parameter int TABLE_DEPTH = 1024,
    parameter int ADDR_W      = 10
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire pwgs_pkg::t_mem_ctl         i_ctl,
    input  wire logic [ADDR_W-1:0]          i_addr,
    input  wire logic [pwgs_pkg::CODE_W-1:0] i_wdata,
    output logic                            o_done,
    output logic [pwgs_pkg::CODE_W-1:0]     o_display_code
);

    logic [pwgs_pkg::CODE_W-1:0] mem [TABLE_DEPTH];
    logic [pwgs_pkg::CODE_W-1:0] r_rd_data;
    logic                        r_out_vld;
    logic                        r_out_sat;

    // reads and writes reach this port in beat order, one per cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            mem[i_addr] <= i_wdata;
        end
        if (i_ctl.conv && !i_ctl.sat) begin
            r_rd_data <= mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= i_ctl.conv;
        end
        r_out_sat <= i_ctl.sat;
    end

    assign o_done         = r_out_vld;
    assign o_display_code = r_out_sat ? pwgs_pkg::OVERLOAD_CODE : r_rd_data;

endmodule

`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// self-checking testbench for the window/level gamma display stretch
// depends on pwgs_pkg and pixel_window_gamma_stretch, nothing else

module tb_top;
    import pwgs_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int TABLE_DEPTH    = 1024;
    localparam int GAIN_FRAC_BITS = 16;
    // gain product carries 16 fraction bits, the level keeps 2
    localparam int LEVEL_SHIFT    = GAIN_FRAC_BITS - LEVEL_FRAC_BITS;
    // registers from a taken convert beat to its code: stage 1, stage 2, result
    localparam int PIPE_LATENCY   = 3;
    localparam int SETTLE_CYCLES  = 2 * PIPE_LATENCY + 2;
    localparam int STALL_LIMIT    = 400;
    localparam int RANDOM_BEATS   = 660;
    localparam int NUM_PHASES     = 10;
    localparam int PHASE_BEATS    = RANDOM_BEATS / NUM_PHASES;

    // ------------------------------------------------------------------
    // scoreboard: own copy of config and gamma table, queue of codes due
    // ------------------------------------------------------------------
    class stretch_scoreboard;
        t_cfg              cfg;
        logic [CODE_W-1:0] gamma_lut [TABLE_DEPTH];
        logic [CODE_W-1:0] pending_codes [$];
        int                errors;

        function new();
            cfg.bytes_per_pixel  = RST_BYTES_PER_PIXEL;
            cfg.saturation_limit = RST_SATURATION_LIMIT;
            cfg.black_offset     = RST_BLACK_OFFSET;
            cfg.level_gain       = RST_LEVEL_GAIN;
            errors = 0;
        endfunction

        function void set_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_BYTES_PER_PIXEL:  cfg.bytes_per_pixel  = data[BPP_W-1:0];
                CFG_SATURATION_LIMIT: cfg.saturation_limit = data[SAMPLE_W-1:0];
                CFG_BLACK_OFFSET:     cfg.black_offset     = data[SAMPLE_W-1:0];
                CFG_LEVEL_GAIN:       cfg.level_gain       = data[GAIN_W-1:0];
                default: ;
            endcase
        endfunction

        // display code for one pixel under the current window and table
        function logic [CODE_W-1:0] stretched_code(logic [BYTE_W-1:0] lo,
                                                   logic [BYTE_W-1:0] hi);
            logic [SAMPLE_W-1:0] sample;
            longint              diff;
            longint              prod;
            longint              lq;
            // byte count 0 acts as 1, 3 acts as 2
            sample = (cfg.bytes_per_pixel >= 2) ? {hi, lo} : {8'h00, lo};
            if (sample > cfg.saturation_limit)
                return OVERLOAD_CODE;
            diff = longint'(sample) - longint'(cfg.black_offset);
            prod = longint'(cfg.level_gain) * diff;
            // arithmetic shift rounds toward minus infinity
            lq = longint'(LEVEL_MID_Q) + (prod >>> LEVEL_SHIFT);
            if (lq < 0)
                lq = 0;
            if (lq > LEVEL_MAX_Q)
                lq = LEVEL_MAX_Q;
            return gamma_lut[lq];
        endfunction

        function void note_beat(logic cmd, logic [BYTE_W-1:0] lo, logic [BYTE_W-1:0] hi,
                                logic [TIDX_W-1:0] tidx, logic [CODE_W-1:0] tval);
            if (cmd == CMD_TABLE_WRITE)
                gamma_lut[tidx] = tval;
            else
                pending_codes.push_back(stretched_code(lo, hi));
        endfunction

        function void check_code(logic [CODE_W-1:0] code);
            logic [CODE_W-1:0] want;
            if (pending_codes.size() == 0) begin
                $display("%0t: display_code expected none, actual %0d", $time, code);
                errors++;
                return;
            end
            want = pending_codes.pop_front();
            if (code !== want) begin
                $display("%0t: display_code expected %0d, actual %0d", $time, want, code);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // block and its ports
    // ------------------------------------------------------------------
    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_start;
    logic                  i_command;
    logic [BYTE_W-1:0]     i_pixel_low_byte;
    logic [BYTE_W-1:0]     i_pixel_high_byte;
    logic [TIDX_W-1:0]     i_table_index;
    logic [CODE_W-1:0]     i_table_value;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  o_busy;
    logic                  o_done;
    logic [CODE_W-1:0]     o_display_code;

    stretch_scoreboard sb;
    int                stall_count = 0;

    pixel_window_gamma_stretch #(
        .TABLE_DEPTH         (TABLE_DEPTH),
        .MAX_BYTES_PER_PIXEL (2),
        .GAIN_FRAC_BITS      (GAIN_FRAC_BITS)
    ) u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (i_start),
        .o_busy            (o_busy),
        .i_command         (i_command),
        .i_pixel_low_byte  (i_pixel_low_byte),
        .i_pixel_high_byte (i_pixel_high_byte),
        .i_table_index     (i_table_index),
        .i_table_value     (i_table_value),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_done            (o_done),
        .o_display_code    (o_display_code)
    );

    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // result side: every strobed code is checked at the edge that ends it
    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            sb.check_code(o_display_code);
    end

    // watchdog: any taken beat or delivered code counts as progress
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_done)
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // drivers: inputs change on the falling edge, handshakes seen on the rising
    // ------------------------------------------------------------------

    // one command beat, held until the block takes it
    task automatic send_beat(input logic cmd, input logic [BYTE_W-1:0] lo,
                             input logic [BYTE_W-1:0] hi, input logic [TIDX_W-1:0] tidx,
                             input logic [CODE_W-1:0] tval);
        @(negedge i_clk);
        i_start           <= 1'b1;
        i_command         <= cmd;
        i_pixel_low_byte  <= lo;
        i_pixel_high_byte <= hi;
        i_table_index     <= tidx;
        i_table_value     <= tval;
        @(posedge i_clk);
        while (o_busy)
            @(posedge i_clk);
        sb.note_beat(cmd, lo, hi, tidx, tval);
    endtask

    // unused fields carry junk, the block must ignore them
    task automatic send_pixel(input logic [BYTE_W-1:0] lo, input logic [BYTE_W-1:0] hi);
        send_beat(CMD_CONVERT, lo, hi, TIDX_W'($urandom), CODE_W'($urandom));
    endtask

    task automatic send_lut(input logic [TIDX_W-1:0] tidx, input logic [CODE_W-1:0] tval);
        send_beat(CMD_TABLE_WRITE, BYTE_W'($urandom), BYTE_W'($urandom), tidx, tval);
    endtask

    // sender quiet, fields wander meanwhile
    task automatic idle_cycles(input int n);
        repeat (n) begin
            @(negedge i_clk);
            i_start          <= 1'b0;
            i_command        <= 1'($urandom);
            i_pixel_low_byte <= BYTE_W'($urandom);
            @(posedge i_clk);
        end
    endtask

    // hold the sender until every code due is out, then let table writes settle
    task automatic drain();
        @(negedge i_clk);
        i_start <= 1'b0;
        while (sb.pending_codes.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES)
            @(posedge i_clk);
    endtask

    // one register write, only called with the pipe empty
    task automatic cfg_write(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic reconfigure(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] data);
        drain();
        cfg_write(idx, data);
    endtask

    // pick a sample that mostly lands inside the window or next to the limit
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        longint top;
        longint span;
        longint s;
        int     r;
        top = (sb.cfg.bytes_per_pixel >= 2) ? 65535 : 255;
        r   = $urandom_range(0, 99);
        if (r < 15) begin
            s = longint'($urandom_range(0, 65535)) % (top + 1);
        end else if (r < 30) begin
            s = longint'(sb.cfg.saturation_limit) + longint'($urandom_range(0, 4)) - 2;
        end else begin
            // half width of the unclamped window, in sample units
            span = (longint'(1) << 23) / (longint'(sb.cfg.level_gain) + 1) + 1;
            if (span > 65535)
                span = 65535;
            s = longint'(sb.cfg.black_offset)
                + longint'($urandom_range(0, 2 * int'(span))) - span;
        end
        if (s < 0)
            s = 0;
        if (s > top)
            s = top;
        return s[SAMPLE_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin
        logic [SAMPLE_W-1:0] s;
        logic [BYTE_W-1:0]   hi;
        logic [BPP_W-1:0]    bpp_val;
        logic [SAMPLE_W-1:0] sat_val;
        logic [SAMPLE_W-1:0] off_val;
        logic [GAIN_W-1:0]   gain_val;
        int                  top;
        int                  idle_pct;
        int                  gap;

        sb                = new();
        i_rst_n           = 1'b0;
        i_start           = 1'b0;
        i_command         = CMD_CONVERT;
        i_pixel_low_byte  = '0;
        i_pixel_high_byte = '0;
        i_table_index     = '0;
        i_table_value     = '0;
        i_cfg_we          = 1'b0;
        i_cfg_index       = CFG_BYTES_PER_PIXEL;
        i_cfg_data        = '0;

        repeat (3)
            @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // fill the whole gamma table first, no pixel may read an unwritten entry
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_lut(TIDX_W'(i), CODE_W'($urandom_range(0, 254)));

        // ---- directed beats ----
        send_lut(10'h3FF, 8'd254);
        send_lut(10'h000, 8'd0);
        // a stored 255 reads back the same as the overload marker
        send_lut(10'd512, 8'd255);
        // reset window: one byte, gain 1.0, offset 0
        send_pixel(8'h00, 8'hFF);
        send_pixel(8'hFF, 8'h00);

        // two bytes, mid scale at 0x8000
        reconfigure(CFG_BYTES_PER_PIXEL, 24'd2);
        reconfigure(CFG_BLACK_OFFSET, 24'h008000);
        send_pixel(8'h00, 8'h80);
        send_pixel(8'hFF, 8'hFF);
        send_pixel(8'h00, 8'h00);
        send_pixel(8'hFF, 8'h7F);

        // tiny gain: one step below offset must floor to the level below mid
        reconfigure(CFG_LEVEL_GAIN, 24'h000001);
        send_pixel(8'hFF, 8'h7F);
        send_pixel(8'h01, 8'h80);

        // saturation edge, sample equal to the limit is still good data
        reconfigure(CFG_SATURATION_LIMIT, 24'h008000);
        send_pixel(8'h01, 8'h80);
        send_pixel(8'h00, 8'h80);
        reconfigure(CFG_SATURATION_LIMIT, 24'h000000);
        send_pixel(8'h00, 8'h00);
        send_pixel(8'h01, 8'h00);

        // byte count 0 acts as one byte, full gain drives the clamps
        reconfigure(CFG_SATURATION_LIMIT, 24'hFFFFFF);
        reconfigure(CFG_BYTES_PER_PIXEL, 24'd0);
        reconfigure(CFG_LEVEL_GAIN, 24'hFFFFFF);
        reconfigure(CFG_BLACK_OFFSET, 24'hFFFFFF);
        send_pixel(8'hFF, 8'hFF);
        send_pixel(8'h00, 8'hFF);
        // byte count 3 acts as two bytes
        reconfigure(CFG_BYTES_PER_PIXEL, 24'd3);
        reconfigure(CFG_BLACK_OFFSET, 24'h000000);
        send_pixel(8'hFF, 8'hFF);
        send_pixel(8'h00, 8'h00);
        // zero gain pins every good sample to mid level
        reconfigure(CFG_LEVEL_GAIN, 24'h000000);
        send_pixel(8'h34, 8'h12);

        // ---- random phases, each with its own window and sender pacing ----
        for (int p = 0; p < NUM_PHASES; p++) begin
            bpp_val = BPP_W'(p % 4);
            top     = (bpp_val >= 2) ? 65535 : 255;
            case (p % 5)
                0:       sat_val = 16'hFFFF;
                1:       sat_val = 16'h0000;
                2:       sat_val = SAMPLE_W'($urandom_range(0, top));
                3:       sat_val = SAMPLE_W'(top - $urandom_range(0, top / 16));
                default: sat_val = 16'hFFFF;
            endcase
            if (p == 2)
                off_val = 16'hFFFF;
            else if (p == 3)
                off_val = 16'h0000;
            else
                off_val = SAMPLE_W'($urandom_range(0, top));
            if (p == 4)
                gain_val = '0;
            else if (p == 5)
                gain_val = 24'hFFFFFF;
            else if (p == 6)
                gain_val = RST_LEVEL_GAIN;
            else
                gain_val = GAIN_W'($urandom_range(1 << 8, 1 << 20));

            // junk in the unused upper data bits must be dropped by the block
            drain();
            cfg_write(CFG_BYTES_PER_PIXEL, {22'($urandom), bpp_val});
            cfg_write(CFG_SATURATION_LIMIT, {8'($urandom), sat_val});
            cfg_write(CFG_BLACK_OFFSET, {8'($urandom), off_val});
            cfg_write(CFG_LEVEL_GAIN, gain_val);

            case (p % 4)
                1:       idle_pct = 62;
                3:       idle_pct = 25;
                default: idle_pct = 0;
            endcase

            for (int n = 0; n < PHASE_BEATS; n++) begin
                // each cycle is idle with the phase's odds
                gap = 0;
                while ($urandom_range(0, 99) < idle_pct)
                    gap++;
                if (idle_pct != 0 && $urandom_range(0, 99) == 0)
                    gap = $urandom_range(4, 20);
                if (gap != 0)
                    idle_cycles(gap);
                // now and then let the pipe run dry mid stream
                if (n == PHASE_BEATS / 2 || $urandom_range(0, 63) == 0)
                    drain();
                if ($urandom_range(0, 99) < 15) begin
                    send_lut(TIDX_W'($urandom),
                             ($urandom_range(0, 15) == 0) ? OVERLOAD_CODE
                                                          : CODE_W'($urandom_range(0, 254)));
                end else begin
                    s  = pick_sample();
                    hi = (sb.cfg.bytes_per_pixel >= 2) ? s[15:8] : BYTE_W'($urandom);
                    send_pixel(s[7:0], hi);
                end
            end
        end

        // wait out every code still due and let the pipe settle
        drain();
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
